// ===== rtl/graph_reachability_query_defines.svh =====
// Assertion macros shared by the graph reachability query RTL.
// No dependencies; included by the top level only.
`ifndef GRAPH_REACHABILITY_QUERY_DEFINES_SVH
`define GRAPH_REACHABILITY_QUERY_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GRQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/grq_pkg.sv =====
// Shared types and constants of the graph reachability query block.
// No dependencies; used by grq_search and graph_reachability_query.
package grq_pkg;

   localparam int NODE_COUNT_W = 6;
   localparam int VERTEX_W     = 5;
   localparam int ROW_W        = 32;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = 2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [ADDR_W-1:0]       ADDR_NODE_COUNT  = 2'd0;
   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 6'd32;

   typedef struct packed {
      logic busy;
      logic done;
      logic reachable;
   } grq_status_type;

endpackage

// ===== rtl/grq_search.sv =====
// Adjacency memory and frontier search engine of the reachability query block.
// Depends on grq_pkg.
module grq_search #(
   parameter int NODES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              take,
   input  logic                              cmd,
   input  logic [grq_pkg::VERTEX_W-1:0]      row_index,
   input  logic [grq_pkg::ROW_W-1:0]         row_bits,
   input  logic [grq_pkg::VERTEX_W-1:0]      query_source,
   input  logic [grq_pkg::VERTEX_W-1:0]      query_target,
   input  logic [grq_pkg::NODE_COUNT_W-1:0]  node_count,
   output grq_pkg::grq_status_type           status
);

   localparam int DEPTH = (NODES < grq_pkg::ROW_W) ? NODES : grq_pkg::ROW_W;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(NODES + 1);
   localparam int NW    = (CW > grq_pkg::NODE_COUNT_W) ? CW : grq_pkg::NODE_COUNT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [DEPTH-1:0] adj_mem [DEPTH];
   logic [DEPTH-1:0] rd_data_ff;

   logic [1:0]       state_ff, state_in;
   logic [DEPTH-1:0] visited_ff, visited_in;
   logic [DEPTH-1:0] pending_ff, pending_in;
   logic [DEPTH-1:0] mask_ff, mask_in;
   logic [AW-1:0]    target_ff, target_in;
   logic             inflight_ff, inflight_in;
   logic             result_ff, result_in;

   logic [NW-1:0]    count_ext, active;
   logic [DEPTH-1:0] mask_now, src_bit, sel_bit, fresh;
   logic [AW-1:0]    sel;
   logic             found, query_ok, row_ok, mem_we, mem_re;

   function automatic logic [AW-1:0] lowest(input logic [DEPTH-1:0] v);
      logic [AW-1:0] idx;
      idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (v[i]) idx = AW'(i);
      end
      return idx;
   endfunction

   assign count_ext = NW'(node_count);
   assign active    = (count_ext > NW'(NODES)) ? NW'(NODES) : count_ext;
   assign query_ok  = (NW'(query_source) < active) && (NW'(query_target) < active);
   assign row_ok    = NW'(row_index) < NW'(NODES);
   assign src_bit   = DEPTH'(1) << query_source[AW-1:0];
   assign sel       = lowest(pending_ff);
   assign sel_bit   = DEPTH'(1) << sel;
   assign found     = pending_ff != '0;
   assign fresh     = rd_data_ff & mask_ff & ~visited_ff;

   always_comb begin
      for (int w = 0; w < DEPTH; w++) begin
         mask_now[w] = NW'(w) < active;
      end
   end

   always_comb begin
      state_in    = state_ff;
      visited_in  = visited_ff;
      pending_in  = pending_ff;
      mask_in     = mask_ff;
      target_in   = target_ff;
      result_in   = result_ff;
      inflight_in = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (cmd == grq_pkg::CMD_LOAD) begin
                  mem_we = row_ok;
               end else begin
                  mask_in   = mask_now;
                  target_in = query_target[AW-1:0];
                  if (query_ok) begin
                     visited_in = src_bit;
                     pending_in = src_bit;
                     state_in   = ST_SEARCH;
                  end else begin
                     result_in = 1'b0;
                     state_in  = ST_FINISH;
                  end
               end
            end
         end
         ST_SEARCH: begin
            mem_re      = found;
            inflight_in = found;
            pending_in  = pending_ff & ~(found ? sel_bit : '0);
            if (inflight_ff) begin
               visited_in = visited_ff | fresh;
               pending_in = pending_in | fresh;
            end
            if (!found && !inflight_ff) begin
               result_in = visited_ff[target_ff];
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (take) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) adj_mem[row_index[AW-1:0]] <= row_bits[DEPTH-1:0];
      if (mem_re) rd_data_ff <= adj_mem[sel];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         inflight_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         inflight_ff <= inflight_in;
      end
      visited_ff <= visited_in;
      pending_ff <= pending_in;
      mask_ff    <= mask_in;
      target_ff  <= target_in;
      result_ff  <= result_in;
   end

   assign status.busy      = state_ff != ST_IDLE;
   assign status.done      = state_ff == ST_FINISH;
   assign status.reachable = result_ff;

endmodule

// ===== rtl/graph_reachability_query.sv =====
// Top level of the directed graph reachability query block.
// Depends on grq_pkg, grq_search and graph_reachability_query_defines.svh.
//
// The block holds a directed graph as an adjacency bit matrix and answers
// whether one vertex reaches another. A load word writes one row and returns
// nothing. A query word returns one word with the reachable flag. The search
// reads one adjacency row per cycle, while the frontier holds a pending
// vertex, through the single read port of the adjacency memory. It idles
// whenever the frontier runs empty while a row read is still in flight, and
// on a long chain that happens at every vertex. A query whose source or target
// is out of range returns its word without a search, with the reachable flag
// clear. The input stays stalled from the acceptance of a query until its
// result moves to the output register, so the next word can be accepted in
// the same cycle as the result word appears. A stalled result word holds a
// following result in the search engine. All rows in use must be loaded
// before the first query.
`include "graph_reachability_query_defines.svh"

module graph_reachability_query #(
   parameter int NODES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [grq_pkg::VERTEX_W-1:0]  req_row_index,
   input  logic [grq_pkg::ROW_W-1:0]     req_row_bits,
   input  logic [grq_pkg::VERTEX_W-1:0]  req_query_source,
   input  logic [grq_pkg::VERTEX_W-1:0]  req_query_target,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_reachable,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [grq_pkg::ADDR_W-1:0]    paddr,
   input  logic [grq_pkg::DATA_W-1:0]    pwdata,
   output logic [grq_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   grq_pkg::grq_status_type status;

   logic [grq_pkg::NODE_COUNT_W-1:0] node_count_ff, node_count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_reachable_ff, rsp_reachable_in;
   logic req_accept, result_take, csr_write;

   assign pready      = 1'b1;
   assign csr_write   = psel && penable && pwrite && pready
                        && (paddr == grq_pkg::ADDR_NODE_COUNT);
   assign prdata      = (paddr == grq_pkg::ADDR_NODE_COUNT)
                        ? grq_pkg::DATA_W'(node_count_ff) : '0;
   assign node_count_in = csr_write ? pwdata[grq_pkg::NODE_COUNT_W-1:0] : node_count_ff;

   assign req_stall   = status.busy;
   assign req_accept  = req_valid && !req_stall;
   assign result_take = status.done && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid_in     = result_take || (rsp_valid_ff && rsp_stall);
   assign rsp_reachable_in = result_take ? status.reachable : rsp_reachable_ff;

   grq_search #(
      .NODES (NODES)
   ) u_search (
      .clock        (clock),
      .reset        (reset),
      .start        (req_accept),
      .take         (result_take),
      .cmd          (req_cmd),
      .row_index    (req_row_index),
      .row_bits     (req_row_bits),
      .query_source (req_query_source),
      .query_target (req_query_target),
      .node_count   (node_count_ff),
      .status       (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= grq_pkg::NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_reachable_ff <= rsp_reachable_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reachable_ff;

   `GRQ_ASSERT_NEXT(a_load_one_cycle, clock, reset,
      req_accept && (req_cmd == grq_pkg::CMD_LOAD), !status.busy,
      "A row load did not complete in one cycle.")
   `GRQ_ASSERT_NEXT(a_query_starts, clock, reset,
      req_accept && (req_cmd == grq_pkg::CMD_QUERY), status.busy,
      "An accepted query did not start a search.")
   `GRQ_ASSERT_NOW(a_result_from_search, clock, reset,
      $rose(rsp_valid_ff), $past(result_take),
      "A result word appeared without a finished search.")

endmodule
